/* design/rbrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrc_pkg
// Shared types and constants of the random byte ring cache: transaction
// structs of both channels, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package rbrc_pkg;

    // Parameter defaults
    localparam int RING_BYTES_DEF  = 256;
    localparam int MAX_REQUEST_DEF = 64;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 7;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Input transaction
    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] sample_byte;
        logic [REQ_W-1:0]  request_count;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              last;
        logic              source_enabled;
    } t_out;

endpackage

/* design/random_byte_ring_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_byte_ring_cache_core
// Ring cache of random bytes in front of a random source. Samples fill the
// ring while the source is enabled; read requests drain it byte by byte.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+---------------------
//  in      | input     | i_in_valid / o_in_stall    | t_in  (sample/read)
//  out     | output    | o_out_valid / i_out_stall  | t_out (byte/status)
//
//  A sample, or a read that yields no byte, gives one status transaction. A
//  read of n bytes gives n byte transactions: the ring RAM is read through
//  its single registered read port, one byte per cycle while the output is
//  not stalled. The input stalls while a read drains and while the output
//  register is full and stalled. Reset clears both indices and enables the
//  source; the ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module random_byte_ring_cache_core
    import rbrc_pkg::*;
#(
    parameter int RING_BYTES  = RING_BYTES_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out,
    input  logic i_out_stall
);

    localparam int IDX_W = $clog2(RING_BYTES);
    localparam int CNT_W = $clog2(MAX_REQUEST + 1);
    localparam int SUM_W = (IDX_W + 1 > REQ_W) ? IDX_W + 1 : REQ_W;

    // Sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic              r_state, n_state;
    logic [IDX_W-1:0]  r_wr, n_wr;
    logic [IDX_W-1:0]  r_rd, n_rd;
    logic              r_running, n_running;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              in_take;
    logic              out_free;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_q;
    logic [IDX_W-1:0]  wr_inc;
    logic [IDX_W-1:0]  rd_inc;
    logic [IDX_W-1:0]  wr_after;
    logic              ring_full;
    logic [IDX_W:0]    stored;
    logic [REQ_W-1:0]  req_cap;
    logic [SUM_W-1:0]  req_x;
    logic [SUM_W-1:0]  stored_x;
    logic [SUM_W-1:0]  cnt_x;
    logic [CNT_W-1:0]  cnt;

    // Advance an index and wrap at the ring size
    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(RING_BYTES - 1)) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Index arithmetic
    assign wr_inc    = ring_inc(r_wr);
    assign rd_inc    = ring_inc(r_rd);
    assign wr_after  = r_running ? wr_inc : r_wr;
    assign ring_full = (ring_inc(wr_after) == r_rd);

    // Bytes held and bytes to hand out
    always_comb begin
        if (r_wr >= r_rd) begin
            stored = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            stored = (IDX_W + 1)'(RING_BYTES) - {1'b0, r_rd} + {1'b0, r_wr};
        end
        if (i_in.request_count > REQ_W'(MAX_REQUEST)) begin
            req_cap = REQ_W'(MAX_REQUEST);
        end else begin
            req_cap = i_in.request_count;
        end
        req_x    = SUM_W'(req_cap);
        stored_x = SUM_W'(stored);
        cnt_x    = (req_x < stored_x) ? req_x : stored_x;
        cnt      = cnt_x[CNT_W-1:0];
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_running   = r_running;
        n_remain    = r_remain;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_in.operation == OP_SAMPLE) begin
                        // Store the sample and stop the source when full
                        ram_we      = r_running;
                        n_wr        = wr_after;
                        n_running   = r_running && !ring_full;
                        n_out_valid = 1'b1;
                        n_out       = '{data_byte: '0, byte_valid: 1'b0, last: 1'b1,
                                        source_enabled: r_running && !ring_full};
                    end else if (cnt == '0) begin
                        // Nothing to give: status only
                        n_out_valid = 1'b1;
                        n_out       = '{data_byte: '0, byte_valid: 1'b0, last: 1'b1,
                                        source_enabled: r_running};
                    end else begin
                        // Fetch the first byte
                        ram_re    = 1'b1;
                        n_rd      = rd_inc;
                        n_remain  = cnt - 1'b1;
                        n_running = 1'b1;
                        n_state   = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    // Hand out the fetched byte and fetch the next
                    n_out_valid = 1'b1;
                    n_out       = '{data_byte: ram_q, byte_valid: 1'b1,
                                    last: (r_remain == '0), source_enabled: r_running};
                    if (r_remain != '0) begin
                        ram_re   = 1'b1;
                        n_rd     = rd_inc;
                        n_remain = r_remain - 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_running   <= 1'b1;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_running   <= n_running;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Byte ring storage
    rbrc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (i_in.sample_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd),
        .o_rdata (ram_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/rbrc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrc_ram
// Generic single-write, single-read RAM with registered read data. The read
// register holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module rbrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rbrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbrc_checker
// Port-level checks of the random byte ring cache core, bound to the top.
// ----------------------------------------------------------------------------
module rbrc_checker
    import rbrc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input t_in  i_in,
    input logic i_in_stall,
    input logic i_out_valid,
    input t_out i_out,
    input logic i_out_stall
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("output transaction changed while stalled");

    // Close every status transaction
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.byte_valid |-> i_out.last)
        else $error("status transaction without last");

    // Block new input while a read still drains
    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.byte_valid && !i_out.last |-> i_in_stall)
        else $error("input taken in the middle of a read");

    // Run the source whenever bytes are handed out
    a_byte_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.byte_valid |-> i_out.source_enabled)
        else $error("byte handed out with source disabled");

endmodule

bind random_byte_ring_cache_core rbrc_checker u_rbrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in        (i_in),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out       (o_out),
    .i_out_stall (i_out_stall)
);

/* test/ring_cache_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_cache_checker
// Watches both channels of the random byte ring cache. Every accepted input
// transaction is run through a local copy of the ring, its indices and the
// source state. The byte and status transactions that it should produce are
// queued, and each accepted output transaction is compared field by field
// with the oldest one in the queue.
// ----------------------------------------------------------------------------
module ring_cache_checker
    import rbrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in,
    input  logic i_in_stall,
    input  logic i_out_valid,
    input  t_out i_out,
    input  logic i_out_stall,
    output int   o_fail_count,
    output int   o_pending
);

    // Local copy of the ring and its bookkeeping
    logic [BYTE_W-1:0] ring_copy [RING_BYTES_DEF];
    int                wr_pos = 0;
    int                rd_pos = 0;
    logic              src_on = 1'b1;
    t_out              ring_results_q [$];
    int                fail_total = 0;

    assign o_fail_count = fail_total;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_total++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advance the local ring by one input transaction and queue its results
    task automatic apply_ring_item(input t_in item);
        int   asked;
        int   stored;
        int   take;
        int   k;
        t_out res;
        res      = '0;
        res.last = 1'b1;
        if (item.operation == OP_SAMPLE) begin
            // Drop the byte while the source is stopped
            if (src_on) begin
                ring_copy[wr_pos] = item.sample_byte;
                wr_pos = (wr_pos + 1) % RING_BYTES_DEF;
            end
            // Keep one slot empty: stop the source when only that one is left
            if ((wr_pos + 1) % RING_BYTES_DEF == rd_pos) begin
                src_on = 1'b0;
            end
            res.source_enabled = src_on;
            ring_results_q.push_back(res);
        end else begin
            asked  = (item.request_count > MAX_REQUEST_DEF) ? MAX_REQUEST_DEF
                                                            : int'(item.request_count);
            stored = (wr_pos - rd_pos + RING_BYTES_DEF) % RING_BYTES_DEF;
            take   = (asked < stored) ? asked : stored;
            if (take == 0) begin
                // Nothing to hand out: one status transaction, source unchanged
                res.source_enabled = src_on;
                ring_results_q.push_back(res);
            end else begin
                // Hand out bytes in order; any byte read restarts the source
                src_on = 1'b1;
                for (k = 0; k < take; k++) begin
                    res.data_byte      = ring_copy[rd_pos];
                    res.byte_valid     = 1'b1;
                    res.last           = (k == take - 1);
                    res.source_enabled = 1'b1;
                    ring_results_q.push_back(res);
                    rd_pos = (rd_pos + 1) % RING_BYTES_DEF;
                end
            end
        end
    endtask

    // Compare one output transaction with the oldest queued result
    task automatic check_result(input t_out got);
        t_out want;
        if (ring_results_q.size() == 0) begin
            report_mismatch("unexpected transaction, data_byte", int'(got.data_byte), 0);
        end else begin
            want = ring_results_q.pop_front();
            if (got.data_byte !== want.data_byte)
                report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
            if (got.last !== want.last)
                report_mismatch("last", int'(got.last), int'(want.last));
            if (got.source_enabled !== want.source_enabled)
                report_mismatch("source_enabled", int'(got.source_enabled),
                                int'(want.source_enabled));
        end
    endtask

    // Track accepted transactions on both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_pos = 0;
            rd_pos = 0;
            src_on = 1'b1;
            ring_results_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_ring_item(i_in);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out);
            end
        end
        o_pending <= ring_results_q.size();
    end

endmodule

/* test/tb_random_byte_ring_cache_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_byte_ring_cache_core
// Drives sample and read transactions into the random byte ring cache:
// a directed opening, then random traffic that fills the ring past full and
// drains it again, with random idle bursts on both channels. Checking is
// done by ring_cache_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_random_byte_ring_cache_core;
    import rbrc_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    logic out_stall = 1'b0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    logic idle_en     = 1'b1;

    always #4 clk = ~clk;

    random_byte_ring_cache_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_data),
        .i_out_stall (out_stall)
    );

    ring_cache_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in         (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out        (out_data),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the output in random bursts, with the output free between bursts
    always @(posedge clk) begin
        if (!idle_en) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!out_stall && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in make_in(input logic op, input logic [BYTE_W-1:0] sample,
                                    input logic [REQ_W-1:0] count);
        t_in item;
        item.operation     = op;
        item.sample_byte   = sample;
        item.request_count = count;
        return item;
    endfunction

    // Random transaction; reads favor small counts but reach past the cap
    function automatic t_in mixed_item(input int sample_pct);
        t_in item;
        int  pick;
        item.operation   = ($urandom_range(0, 99) < sample_pct) ? OP_SAMPLE : OP_READ;
        item.sample_byte = BYTE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            item.request_count = REQ_W'($urandom_range(0, 8));
        else if (pick < 7)
            item.request_count = REQ_W'($urandom_range(9, 64));
        else if (pick < 9)
            item.request_count = REQ_W'($urandom_range(65, 127));
        else
            item.request_count = REQ_W'($urandom_range(0, 1));
        return item;
    endfunction

    // Mostly samples, with an occasional empty read as noise
    function automatic t_in fill_item();
        t_in item;
        item = mixed_item(100);
        if ($urandom_range(0, 99) < 3) begin
            item.operation     = OP_READ;
            item.request_count = '0;
        end
        return item;
    endfunction

    // Present one transaction, after an optional idle burst, and hold it until taken
    task automatic send_item(input t_in item);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reads from an empty ring
        send_item(make_in(OP_READ, 8'h00, 7'd0));
        send_item(make_in(OP_READ, 8'h00, 7'd64));
        // Extreme sample bytes
        send_item(make_in(OP_SAMPLE, 8'h00, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'hFF, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'hA5, 7'd0));
        // Zero count on a non-empty ring, a single byte, then an oversized request
        send_item(make_in(OP_READ, 8'h00, 7'd0));
        send_item(make_in(OP_READ, 8'h00, 7'd1));
        send_item(make_in(OP_READ, 8'h00, 7'd127));
        send_item(make_in(OP_READ, 8'h00, 7'd3));
        send_item(make_in(OP_SAMPLE, 8'h5A, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'h01, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'h80, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'h7F, 7'd0));
        send_item(make_in(OP_SAMPLE, 8'hC3, 7'd0));
        // Request just above the cap, then exactly the cap
        send_item(make_in(OP_READ, 8'h00, 7'd65));
        send_item(make_in(OP_SAMPLE, 8'h3C, 7'd0));
        send_item(make_in(OP_READ, 8'h00, 7'd64));
        // Unused fields set to their extremes
        send_item(make_in(OP_SAMPLE, 8'h96, 7'd127));
        send_item(make_in(OP_READ, 8'hFF, 7'd2));

        // Mixed traffic at a low fill level
        for (k = 0; k < 20; k++) begin
            send_item(mixed_item(50));
        end
        // Fill past full so that samples get dropped, with a quiet stretch
        for (k = 0; k < 275; k++) begin
            if (k == 120) idle_en = 1'b0;
            if (k == 160) idle_en = 1'b1;
            send_item(fill_item());
        end
        // Drain with read-heavy traffic, no idling to the end
        idle_en = 1'b0;
        for (k = 0; k < 20; k++) begin
            send_item(mixed_item(25));
        end
        in_valid <= 1'b0;

        // Wait for every queued result, then a short settle
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* random_byte_ring_cache_core.f */
design/rbrc_pkg.sv
design/rbrc_ram.sv
design/random_byte_ring_cache_core.sv
design/rbrc_checker.sv
test/ring_cache_checker.sv
test/tb_random_byte_ring_cache_core.sv
